>>> src/uart_8n1_with_fifos_defines.svh
// Assertion shorthands, clocked on aclk with reset held off.
`ifndef UART_8N1_WITH_FIFOS_DEFINES_SVH
`define UART_8N1_WITH_FIFOS_DEFINES_SVH

`define UWF_ASSERT_NOW(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("uart_8n1_with_fifos: invariant violated");

`define UWF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("uart_8n1_with_fifos: same-cycle check failed");

`define UWF_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("uart_8n1_with_fifos: next-cycle check failed");

`endif

>>> src/uwf_pkg.sv
package uwf_pkg;

    localparam int TX_DEPTH = 16;
    localparam int RX_DEPTH = 16;
    localparam int TX_PTR_W = $clog2(TX_DEPTH);
    localparam int RX_PTR_W = $clog2(RX_DEPTH);
    localparam int TX_CNT_W = $clog2(TX_DEPTH + 1);
    localparam int RX_CNT_W = $clog2(RX_DEPTH + 1);

    localparam int PERIOD_W = 16;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1250;
    localparam logic [PERIOD_W-1:0] PERIOD_MIN   = 16'd4;

    // bits still to go after the start bit goes out / after the falling edge
    localparam logic [3:0] TX_FRAME_BITS  = 4'd9;
    localparam logic [3:0] RX_FRAME_BITS  = 4'd10;
    localparam logic [3:0] RX_START_CHECK = 4'd9;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    typedef struct packed {
        logic [4:0] pad;
        logic       rx_line;
        logic       pop_request;
        logic [7:0] tx_byte;
        logic       push_valid;
    } in_item_t;

    typedef struct packed {
        logic [1:0] pad;
        logic       rx_dropped;
        logic       tx_fifo_full;
        logic       rx_not_empty;
        logic       rx_byte_valid;
        logic [7:0] rx_byte;
        logic       push_accepted;
        logic       tx_line;
    } out_item_t;

    // one clock tick as seen by the transmitter and receiver
    typedef struct packed {
        logic                step;
        logic                wrap;
        logic [PERIOD_W-1:0] timer;
        logic [PERIOD_W-1:0] period;
        logic                cfg_abort;
    } tick_t;

    typedef struct packed {
        logic                level;
        logic                accepted;
        logic                full;
        logic [TX_CNT_W-1:0] count;
    } tx_stat_t;

    typedef struct packed {
        logic [7:0]          data;
        logic                data_valid;
        logic                not_empty;
        logic                dropped;
        logic [RX_CNT_W-1:0] count;
    } rx_stat_t;

endpackage

>>> src/uwf_tx.sv
module uwf_tx
    import uwf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  tick_t      tick,
    input  logic       push_valid,
    input  logic [7:0] tx_byte,
    output tx_stat_t   stat
);

    logic [7:0]          store_reg [TX_DEPTH];
    logic [TX_PTR_W-1:0] head_reg, head_next;
    logic [TX_PTR_W-1:0] tail_reg, tail_next;
    logic [TX_CNT_W-1:0] count_reg, count_next, count_after;
    logic [7:0]          shift_reg, shift_next;
    logic [3:0]          bits_left_reg, bits_left_next;
    logic                level_reg, level_next;
    logic                deq, push_ok;

    always_comb begin
        shift_next     = shift_reg;
        bits_left_next = bits_left_reg;
        level_next     = level_reg;
        tail_next      = tail_reg;
        deq            = 1'b0;
        if (tick.wrap) begin
            if (bits_left_reg != 4'd0) begin
                if (bits_left_reg > 4'd1) begin
                    level_next = shift_reg[0];
                    shift_next = {1'b0, shift_reg[7:1]};
                end else begin
                    level_next = 1'b1;
                end
                bits_left_next = bits_left_reg - 4'd1;
            end else if (count_reg != '0) begin
                deq            = 1'b1;
                shift_next     = store_reg[tail_reg];
                tail_next      = (tail_reg == TX_PTR_W'(TX_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
                bits_left_next = TX_FRAME_BITS;
                level_next     = 1'b0;
            end
        end
        count_after = count_reg - TX_CNT_W'(deq);
        push_ok     = push_valid && (count_after < TX_CNT_W'(TX_DEPTH));
        count_next  = count_after + TX_CNT_W'(push_ok);
        head_next   = push_ok
                    ? ((head_reg == TX_PTR_W'(TX_DEPTH - 1)) ? '0 : head_reg + 1'b1)
                    : head_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            shift_reg     <= '0;
            bits_left_reg <= '0;
            level_reg     <= 1'b1;
        end else if (tick.step) begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            shift_reg     <= shift_next;
            bits_left_reg <= bits_left_next;
            level_reg     <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (tick.step && push_ok) begin
            store_reg[head_reg] <= tx_byte;
        end
    end

    assign stat.level    = level_next;
    assign stat.accepted = push_ok;
    assign stat.full     = (count_next == TX_CNT_W'(TX_DEPTH));
    assign stat.count    = count_reg;

endmodule

>>> src/uwf_rx.sv
module uwf_rx
    import uwf_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  tick_t    tick,
    input  logic     pop_request,
    input  logic     rx_line,
    output rx_stat_t stat
);

    logic [7:0]          store_reg [RX_DEPTH];
    logic [RX_PTR_W-1:0] head_reg, head_next;
    logic [RX_PTR_W-1:0] tail_reg, tail_next;
    logic [RX_CNT_W-1:0] count_reg, count_next, count_after;
    logic [7:0]          shift_reg, shift_next;
    logic [3:0]          bits_left_reg, bits_left_next, bits_dec;
    logic [PERIOD_W-1:0] phase_reg, phase_next;
    logic                busy_reg, busy_next;
    logic                last_level_reg;
    logic                pop, push, dropped;
    logic [7:0]          pop_val;
    logic [PERIOD_W-1:0] tc, half;
    logic [PERIOD_W:0]   phase_wrap;

    always_comb begin
        pop         = pop_request && (count_reg != '0);
        pop_val     = pop ? store_reg[tail_reg] : 8'd0;
        tail_next   = pop ? ((tail_reg == RX_PTR_W'(RX_DEPTH - 1)) ? '0 : tail_reg + 1'b1)
                          : tail_reg;
        count_after = count_reg - RX_CNT_W'(pop);

        // sampling point half a bit after the detected edge, kept inside one period
        tc         = (tick.timer >= tick.period) ? tick.period - 1'b1 : tick.timer;
        half       = tick.period >> 1;
        phase_wrap = {1'b0, tc} + {1'b0, tick.period} - {1'b0, half};

        shift_next     = shift_reg;
        bits_left_next = bits_left_reg;
        phase_next     = phase_reg;
        busy_next      = busy_reg;
        push           = 1'b0;
        dropped        = 1'b0;
        bits_dec       = (bits_left_reg != 4'd0) ? bits_left_reg - 4'd1 : bits_left_reg;

        if (busy_reg) begin
            if (tick.timer == phase_reg) begin
                bits_left_next = bits_dec;
                if (bits_dec == RX_START_CHECK) begin
                    if (rx_line) begin
                        busy_next = 1'b0;   // false start
                    end
                end else if (bits_dec != 4'd0) begin
                    shift_next = {rx_line, shift_reg[7:1]};
                end else begin
                    if (rx_line && (count_after < RX_CNT_W'(RX_DEPTH))) begin
                        push = 1'b1;
                    end else begin
                        dropped = 1'b1;
                    end
                    busy_next = 1'b0;
                end
            end
        end else if (last_level_reg && !rx_line) begin
            phase_next     = (tc >= half) ? tc - half : phase_wrap[PERIOD_W-1:0];
            bits_left_next = RX_FRAME_BITS;
            busy_next      = 1'b1;
        end

        count_next = count_after + RX_CNT_W'(push);
        head_next  = push ? ((head_reg == RX_PTR_W'(RX_DEPTH - 1)) ? '0 : head_reg + 1'b1)
                          : head_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            shift_reg      <= '0;
            bits_left_reg  <= '0;
            phase_reg      <= '0;
            busy_reg       <= 1'b0;
            last_level_reg <= 1'b1;
        end else begin
            if (tick.step) begin
                head_reg       <= head_next;
                tail_reg       <= tail_next;
                count_reg      <= count_next;
                shift_reg      <= shift_next;
                phase_reg      <= phase_next;
                last_level_reg <= rx_line;
            end
            // a new bit period abandons any frame being received
            if (tick.cfg_abort) begin
                busy_reg      <= 1'b0;
                bits_left_reg <= '0;
            end else if (tick.step) begin
                busy_reg      <= busy_next;
                bits_left_reg <= bits_left_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (tick.step && push) begin
            store_reg[head_reg] <= shift_reg;
        end
    end

    assign stat.data       = pop_val;
    assign stat.data_valid = pop;
    assign stat.not_empty  = (count_next != '0);
    assign stat.dropped    = dropped;
    assign stat.count      = count_reg;

endmodule

>>> src/uart_8n1_with_fifos.sv
// Channel   Direction  Contents of one item
// s_        in         one clock tick of the UART: push, byte, pop, rx pin sample
// m_        out        pin level, push/pop results and FIFO flags after that tick
// cfg_      in         bit_period write, taken at once
//
// One item per cycle sustained while m_ does not stall; an item is held in the input
// register, and the result register takes its outcome when the tick steps, so the result
// is offered on m_ from the result register after that step.
// The whole tick (timer, shifters, FIFO pointers) updates in the single step between
// the two registers. A stall on m_ holds the result register and backs up into the
// input register. Reset (aresetn low, synchronous) empties both FIFOs, idles tx high,
// and sets bit_period to 1250.
`include "uart_8n1_with_fifos_defines.svh"

module uart_8n1_with_fifos
    import uwf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [0] push_valid, [8:1] tx_byte, [9] pop_request, [10] rx_line, [15:11] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [0] tx_line, [1] push_accepted, [9:2] rx_byte, [10] rx_byte_valid,
    // [11] rx_not_empty, [12] tx_fifo_full, [13] rx_dropped, [15:14] zero
    output logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 cfg_wr_en,
    input  logic [PERIOD_W-1:0]  cfg_wr_data
);

    logic                in_valid_reg;
    in_item_t            in_item_reg;
    logic                m_valid_reg;
    out_item_t           m_item_reg, m_item_next;
    logic [PERIOD_W-1:0] period_reg;
    logic [PERIOD_W-1:0] timer_reg;
    logic [PERIOD_W-1:0] period_eff;
    logic                step, wrap;
    tick_t               tick;
    tx_stat_t            tx_stat;
    rx_stat_t            rx_stat;

    assign step     = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_item_reg;

    assign period_eff = (period_reg < PERIOD_MIN) ? PERIOD_MIN : period_reg;
    assign wrap       = (timer_reg >= period_eff - 1'b1);

    assign tick.step      = step;
    assign tick.wrap      = wrap;
    assign tick.timer     = timer_reg;
    assign tick.period    = period_eff;
    assign tick.cfg_abort = cfg_wr_en;

    uwf_tx u_tx (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .tick       (tick),
        .push_valid (in_item_reg.push_valid),
        .tx_byte    (in_item_reg.tx_byte),
        .stat       (tx_stat)
    );

    uwf_rx u_rx (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .tick        (tick),
        .pop_request (in_item_reg.pop_request),
        .rx_line     (in_item_reg.rx_line),
        .stat        (rx_stat)
    );

    always_comb begin
        m_item_next               = '0;
        m_item_next.tx_line       = tx_stat.level;
        m_item_next.push_accepted = tx_stat.accepted;
        m_item_next.rx_byte       = rx_stat.data;
        m_item_next.rx_byte_valid = rx_stat.data_valid;
        m_item_next.rx_not_empty  = rx_stat.not_empty;
        m_item_next.tx_fifo_full  = tx_stat.full;
        m_item_next.rx_dropped    = rx_stat.dropped;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            timer_reg    <= '0;
            period_reg   <= PERIOD_RESET;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (step) begin
                in_valid_reg <= 1'b0;
            end
            if (step) begin
                m_valid_reg <= 1'b1;
                timer_reg   <= wrap ? '0 : timer_reg + 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                period_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= s_tdata;
        end
        if (step) begin
            m_item_reg <= m_item_next;
        end
    end

    `UWF_ASSERT_NOW(a_tx_count_bound, tx_stat.count <= TX_CNT_W'(TX_DEPTH))
    `UWF_ASSERT_NOW(a_rx_count_bound, rx_stat.count <= RX_CNT_W'(RX_DEPTH))
    `UWF_ASSERT_NXT(a_timer_wraps, step && wrap, timer_reg == '0)
    `UWF_ASSERT_IMP(a_no_pop_zero, m_valid_reg && !m_item_reg.rx_byte_valid, m_item_reg.rx_byte == 8'd0)

endmodule
